### sv/bwns_pkg.sv
package bwns_pkg;

    // Field widths of the stream and register interfaces.
    localparam int COORD_W  = 12;
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 3 * CHAN_W;
    localparam int COEF_W   = 40;
    localparam int FRAC_W   = 24;
    localparam int SUM_W    = 64;
    localparam int NUM_COEF = 8;

    // APB register map: one 64-bit slot per coefficient.
    localparam int PDATA_W      = 64;
    localparam int REG_ADDR_LSB = 3;
    localparam int PADDR_W      = REG_ADDR_LSB + $clog2(NUM_COEF);

    // The x*y coefficient is split at this bit for two narrower multipliers.
    localparam int SPLIT_W = 20;

    localparam logic [CHAN_W-1:0] BACKGROUND = 8'd128;
    localparam logic [SUM_W-1:0]  HALF_ONE   = 64'h0000_0000_0080_0000;

    typedef logic signed [COEF_W-1:0] coef_t;

    localparam coef_t COEF_ONE = 40'sh00_0100_0000;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_MAP  = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        REG_X_XY    = 3'd0,
        REG_X_X     = 3'd1,
        REG_X_Y     = 3'd2,
        REG_X_CONST = 3'd3,
        REG_Y_XY    = 3'd4,
        REG_Y_X     = 3'd5,
        REG_Y_Y     = 3'd6,
        REG_Y_CONST = 3'd7
    } reg_idx_t;

    // Result of rounding one mapped coordinate.
    typedef struct packed
    {
        logic               ok;
        logic [COORD_W-1:0] coord;
    } coord_res_t;

endpackage

### sv/bilinear_warp_nearest_sampler_core.sv
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tdata: pos_x, pos_y, red, green, blue; tuser: command
// m_*       out        m_tvalid/m_tready  tdata: red, green, blue; tuser: inside
// apb       in/out     psel/penable       eight 40-bit coefficients at 8-byte steps
//
// One item enters per cycle while the output does not stall; each map item yields one result transaction.
// A load writes the frame store in stage six and produces no result transaction.
// Seven stages: input capture, products, partial products, sums, rounding, address, memory read.
// A stall at the output backs up stage by stage, and empty stages keep filling meanwhile.
// Reset clears the stage valid bits and restores the identity coefficients; the frame store
// is not cleared.
module bilinear_warp_nearest_sampler_core
    import bwns_pkg::*;
#(
    parameter int SRC_WIDTH  = 256,
    parameter int SRC_HEIGHT = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [47:0]              s_tdata,   // pos_x, pos_y, in_red, in_green, in_blue
    input  logic [0:0]               s_tuser,   // command

    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [23:0]              m_tdata,   // out_red, out_green, out_blue
    output logic [0:0]               m_tuser,   // inside_res

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    localparam int DEPTH      = SRC_WIDTH * SRC_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int NUM_STAGES = 7;
    localparam int LIM_W      = COORD_W + 1;
    localparam int Q_W        = SUM_W - FRAC_W;
    localparam int LADDR_W    = 2 * COORD_W + 1;
    localparam int LPROD_W    = COEF_W + COORD_W + 1;
    localparam int HI_W       = COEF_W - SPLIT_W + 2 * COORD_W + 1;
    localparam int LO_W       = SPLIT_W + 2 * COORD_W;

    localparam logic [LIM_W-1:0] WIDTH_LIM  = LIM_W'(SRC_WIDTH);
    localparam logic [LIM_W-1:0] HEIGHT_LIM = LIM_W'(SRC_HEIGHT);

    // Rounds a 24-fraction sum, to which one half was already added, by truncating toward zero.
    // A negative sum above minus one rounds to coordinate zero.
    function automatic coord_res_t round_coord(input logic [SUM_W-1:0] t,
                                               input logic [LIM_W-1:0] limit);
        coord_res_t       r;
        logic [Q_W-1:0]   q;
        q = t[SUM_W-1:FRAC_W];
        r.ok = 1'b0;
        r.coord = '0;
        if (t[SUM_W-1])
        begin
            r.ok = (&q) && (|t[FRAC_W-1:0]);
        end
        else if (q < Q_W'(limit))
        begin
            r.ok = 1'b1;
            r.coord = q[COORD_W-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Coefficient registers and APB access.
    // ------------------------------------------------------------------
    coef_t                       coef_reg [NUM_COEF];
    logic [$clog2(NUM_COEF)-1:0] reg_sel;
    logic                        cfg_we;

    assign reg_sel = paddr[PADDR_W-1:REG_ADDR_LSB];
    assign cfg_we  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = PDATA_W'(coef_reg[reg_sel]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                if (i == int'(REG_X_X) || i == int'(REG_Y_Y))
                begin
                    coef_reg[i] <= COEF_ONE;
                end
                else
                begin
                    coef_reg[i] <= '0;
                end
            end
        end
        else if (cfg_we)
        begin
            coef_reg[reg_sel] <= pwdata[COEF_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and advance enables.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] en;

    // A stage takes new contents when it is empty or its successor advances.
    always_comb
    begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k + 1];
        end
    end

    assign s_tready = en[0];

    // Stage six carries the command forward; loads leave the pipeline there.
    cmd_t cmd6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES - 1; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k - 1];
                end
            end
            if (en[NUM_STAGES-1])
            begin
                valid_reg[NUM_STAGES-1] <= valid_reg[NUM_STAGES-2] && (cmd6_reg == CMD_MAP);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input capture.
    // ------------------------------------------------------------------
    cmd_t               cmd1_reg;
    logic [COORD_W-1:0] x1_reg;
    logic [COORD_W-1:0] y1_reg;
    logic [PIX_W-1:0]   pix1_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cmd1_reg <= cmd_t'(s_tuser[0]);
            x1_reg   <= s_tdata[COORD_W-1:0];
            y1_reg   <= s_tdata[2*COORD_W-1:COORD_W];
            pix1_reg <= s_tdata[2*COORD_W+PIX_W-1:2*COORD_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: x*y and the linear products.
    // ------------------------------------------------------------------
    cmd_t                       cmd2_reg;
    logic [COORD_W-1:0]         x2_reg;
    logic [COORD_W-1:0]         y2_reg;
    logic [PIX_W-1:0]           pix2_reg;
    logic [2*COORD_W-1:0]       xy2_reg;
    logic signed [LPROD_W-1:0]  pxx2_reg;
    logic signed [LPROD_W-1:0]  pxy2_reg;
    logic signed [LPROD_W-1:0]  pyx2_reg;
    logic signed [LPROD_W-1:0]  pyy2_reg;

    logic [2*COORD_W-1:0]       xy2_next;
    logic signed [LPROD_W-1:0]  pxx2_next;
    logic signed [LPROD_W-1:0]  pxy2_next;
    logic signed [LPROD_W-1:0]  pyx2_next;
    logic signed [LPROD_W-1:0]  pyy2_next;

    assign xy2_next  = x1_reg * y1_reg;
    assign pxx2_next = coef_reg[REG_X_X] * $signed({1'b0, x1_reg});
    assign pxy2_next = coef_reg[REG_X_Y] * $signed({1'b0, y1_reg});
    assign pyx2_next = coef_reg[REG_Y_X] * $signed({1'b0, x1_reg});
    assign pyy2_next = coef_reg[REG_Y_Y] * $signed({1'b0, y1_reg});

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            cmd2_reg <= cmd1_reg;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            pix2_reg <= pix1_reg;
            xy2_reg  <= xy2_next;
            pxx2_reg <= pxx2_next;
            pxy2_reg <= pxy2_next;
            pyx2_reg <= pyx2_next;
            pyy2_reg <= pyy2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: split x*y products and the linear sums with one half.
    // ------------------------------------------------------------------
    cmd_t                    cmd3_reg;
    logic [COORD_W-1:0]      x3_reg;
    logic [COORD_W-1:0]      y3_reg;
    logic [PIX_W-1:0]        pix3_reg;
    logic signed [HI_W-1:0]  hix3_reg;
    logic [LO_W-1:0]         lox3_reg;
    logic [SUM_W-1:0]        linx3_reg;
    logic signed [HI_W-1:0]  hiy3_reg;
    logic [LO_W-1:0]         loy3_reg;
    logic [SUM_W-1:0]        liny3_reg;

    logic signed [HI_W-1:0]  hix3_next;
    logic [LO_W-1:0]         lox3_next;
    logic [SUM_W-1:0]        linx3_next;
    logic signed [HI_W-1:0]  hiy3_next;
    logic [LO_W-1:0]         loy3_next;
    logic [SUM_W-1:0]        liny3_next;
    coef_t                   cxy;
    coef_t                   cyy;

    assign cxy = coef_reg[REG_X_XY];
    assign cyy = coef_reg[REG_Y_XY];

    assign hix3_next = $signed(cxy[COEF_W-1:SPLIT_W]) * $signed({1'b0, xy2_reg});
    assign lox3_next = cxy[SPLIT_W-1:0] * xy2_reg;
    assign hiy3_next = $signed(cyy[COEF_W-1:SPLIT_W]) * $signed({1'b0, xy2_reg});
    assign loy3_next = cyy[SPLIT_W-1:0] * xy2_reg;

    assign linx3_next = SUM_W'(pxx2_reg) + SUM_W'(pxy2_reg)
                      + SUM_W'(coef_reg[REG_X_CONST]) + HALF_ONE;
    assign liny3_next = SUM_W'(pyx2_reg) + SUM_W'(pyy2_reg)
                      + SUM_W'(coef_reg[REG_Y_CONST]) + HALF_ONE;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            cmd3_reg  <= cmd2_reg;
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
            pix3_reg  <= pix2_reg;
            hix3_reg  <= hix3_next;
            lox3_reg  <= lox3_next;
            linx3_reg <= linx3_next;
            hiy3_reg  <= hiy3_next;
            loy3_reg  <= loy3_next;
            liny3_reg <= liny3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: full 64-bit sums, wrapping like two's complement.
    // ------------------------------------------------------------------
    cmd_t               cmd4_reg;
    logic [COORD_W-1:0] x4_reg;
    logic [COORD_W-1:0] y4_reg;
    logic [PIX_W-1:0]   pix4_reg;
    logic [SUM_W-1:0]   tx4_reg;
    logic [SUM_W-1:0]   ty4_reg;

    logic [SUM_W-1:0]   tx4_next;
    logic [SUM_W-1:0]   ty4_next;

    assign tx4_next = (SUM_W'(hix3_reg) << SPLIT_W) + SUM_W'(lox3_reg) + linx3_reg;
    assign ty4_next = (SUM_W'(hiy3_reg) << SPLIT_W) + SUM_W'(loy3_reg) + liny3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            cmd4_reg <= cmd3_reg;
            x4_reg   <= x3_reg;
            y4_reg   <= y3_reg;
            pix4_reg <= pix3_reg;
            tx4_reg  <= tx4_next;
            ty4_reg  <= ty4_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: rounding and range check; loads check their own position.
    // ------------------------------------------------------------------
    cmd_t               cmd5_reg;
    logic [PIX_W-1:0]   pix5_reg;
    logic               ok5_reg;
    logic [COORD_W-1:0] sx5_reg;
    logic [COORD_W-1:0] sy5_reg;

    coord_res_t         rx;
    coord_res_t         ry;
    logic               ok5_next;
    logic [COORD_W-1:0] sx5_next;
    logic [COORD_W-1:0] sy5_next;

    always_comb
    begin
        rx = round_coord(tx4_reg, WIDTH_LIM);
        ry = round_coord(ty4_reg, HEIGHT_LIM);
        if (cmd4_reg == CMD_MAP)
        begin
            ok5_next = rx.ok && ry.ok;
            sx5_next = rx.coord;
            sy5_next = ry.coord;
        end
        else
        begin
            ok5_next = ({1'b0, x4_reg} < WIDTH_LIM) && ({1'b0, y4_reg} < HEIGHT_LIM);
            sx5_next = x4_reg;
            sy5_next = y4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            cmd5_reg <= cmd4_reg;
            pix5_reg <= pix4_reg;
            ok5_reg  <= ok5_next;
            sx5_reg  <= sx5_next;
            sy5_reg  <= sy5_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: frame store address.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]   pix6_reg;
    logic               ok6_reg;
    logic [ADDR_W-1:0]  addr6_reg;

    logic [LADDR_W-1:0] lin_addr;

    assign lin_addr = LADDR_W'(sy5_reg) * LADDR_W'(WIDTH_LIM) + LADDR_W'(sx5_reg);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            cmd6_reg  <= cmd5_reg;
            pix6_reg  <= pix5_reg;
            ok6_reg   <= ok5_reg;
            addr6_reg <= lin_addr[ADDR_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: frame store access; loads write, maps read.
    // ------------------------------------------------------------------
    logic             ram_we;
    logic             ram_re;
    logic [PIX_W-1:0] ram_rdata;
    logic             ok7_reg;

    assign ram_we = en[6] && valid_reg[5] && (cmd6_reg == CMD_LOAD) && ok6_reg;
    assign ram_re = en[6] && valid_reg[5] && (cmd6_reg == CMD_MAP) && ok6_reg;

    bwns_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr6_reg),
        .wdata (pix6_reg),
        .re    (ram_re),
        .raddr (addr6_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            ok7_reg <= ok6_reg;
        end
    end

    // Output: sampled pixel or gray background.
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tuser  = ok7_reg;
    assign m_tdata  = ok7_reg ? ram_rdata : {BACKGROUND, BACKGROUND, BACKGROUND};

`ifndef SYNTHESIS
    // A stage-six item either writes or reads the store, never both.
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
        else $error("frame store written and read in the same cycle");

    // A point outside the frame delivers the gray background.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == {BACKGROUND, BACKGROUND, BACKGROUND}))
        else $error("outside point without background color");

    // An empty first stage always takes a transaction.
    assert property (@(posedge clk) disable iff (!rst_n) !valid_reg[0] |-> s_tready)
        else $error("input stalled while first stage is empty");

    // An item held in stage six keeps its address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[5] && !en[6]) |=> (valid_reg[5] && $stable(addr6_reg)))
        else $error("stalled stage six item lost or changed");
`endif

endmodule

### sv/bwns_ram.sv
module bwns_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
